### hdl/rbdl_pkg.sv
package rbdl_pkg;

    // Field widths of the request and result words.
    localparam int MODE_W    = 4;
    localparam int INDEX_W   = 7;
    localparam int VALUE_W   = 32;
    localparam int STATUS_W  = 2;
    localparam int COUNT_W   = 7;
    localparam int CAP_W     = 7;

    localparam int IN_TDATA_W  = ((MODE_W + INDEX_W + VALUE_W + 7) / 8) * 8;
    localparam int OUT_TDATA_W = ((VALUE_W + STATUS_W + COUNT_W + 7) / 8) * 8;

    // Default sizing of the slot store.
    localparam int DEPTH_DEF       = 64;
    localparam int ENTRY_WIDTH_DEF = 32;

    typedef enum logic [MODE_W-1:0] {
        MODE_ADD_TAIL     = 4'd0,
        MODE_ADD_HEAD     = 4'd1,
        MODE_REMOVE_HEAD  = 4'd2,
        MODE_REMOVE_TAIL  = 4'd3,
        MODE_INSERT_AT    = 4'd4,
        MODE_REMOVE_AT    = 4'd5,
        MODE_GET_AT       = 4'd6,
        MODE_REMOVE_VALUE = 4'd7,
        MODE_GET_TAIL     = 4'd8
    } t_mode;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK    = 2'd0,
        STAT_FULL  = 2'd1,
        STAT_RANGE = 2'd2,
        STAT_EMPTY = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_READ,
        ST_SCAN,
        ST_MOVE,
        ST_DONE
    } t_state;

endpackage

### hdl/rbdl_slot_ram.sv
module rbdl_slot_ram #(
    parameter int DEPTH = rbdl_pkg::DEPTH_DEF,
    parameter int WIDTH = rbdl_pkg::ENTRY_WIDTH_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    import rbdl_pkg::*;

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // One write port and one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### hdl/ring_buffer_deque_list.sv
// Ordered list of entry words held in a circular slot store, addressed as a
// deque with indexed access. One request word on the slave stream names an
// operation (push or pop at either end, insert, remove or read at an index,
// read the tail, or remove the first entry equal to a value); exactly one
// result word follows on the master stream with the value, a status and the
// entry count after the request.
// The capacity register is written through i_cfg_we / i_cfg_wdata; the user
// must do so only while idle, unchecked by the block. A write empties the
// list; reset too, and sets the capacity to DEPTH. Slots are not cleared.
// Flow: a request is taken only in the idle state. A push, or a request
// refused at its start, goes from execute straight to done; a pop or a read
// passes through a read state first. An insert at an index moves the
// entries from the tail down to the index, a remove at an index moves the
// entries behind it towards the head, and a remove by value first scans
// from the head for the first match. The single slot memory, one read and
// one write per cycle, bounds this: each moved entry is read once.
// A finished result sits in an output register; while the receiver stalls,
// the next request is still taken and worked on, and it waits in the done
// state only once it has its own result ready.
module ring_buffer_deque_list #(
    parameter int DEPTH       = rbdl_pkg::DEPTH_DEF,
    parameter int ENTRY_WIDTH = rbdl_pkg::ENTRY_WIDTH_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // Capacity register write.
    input  logic                             i_cfg_we,
    input  logic [rbdl_pkg::CAP_W-1:0]       i_cfg_wdata,
    // Request stream.
    input  logic                             i_s_axis_tvalid,
    output logic                             o_s_axis_tready,
    // Fields from bit 0: mode (4), index (7), value (32), zero fill.
    input  logic [rbdl_pkg::IN_TDATA_W-1:0]  i_s_axis_tdata,
    // Result stream.
    output logic                             o_m_axis_tvalid,
    input  logic                             i_m_axis_tready,
    // Fields from bit 0: result_value (32), status (2), entry_count (7), zero fill.
    output logic [rbdl_pkg::OUT_TDATA_W-1:0] o_m_axis_tdata
);
    import rbdl_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int SW = (ENTRY_WIDTH < VALUE_W) ? ENTRY_WIDTH : VALUE_W;
    localparam int XW = (CW > INDEX_W) ? CW : INDEX_W;

    // Unpacked request fields.
    logic [MODE_W-1:0]  w_in_mode;
    logic [INDEX_W-1:0] w_in_index;
    logic [VALUE_W-1:0] w_in_value;

    assign w_in_mode  = i_s_axis_tdata[MODE_W-1:0];
    assign w_in_index = i_s_axis_tdata[MODE_W +: INDEX_W];
    assign w_in_value = i_s_axis_tdata[MODE_W + INDEX_W +: VALUE_W];

    // Control and list state.
    t_state             r_state, n_state;
    logic [MODE_W-1:0]  r_mode, n_mode;
    logic [INDEX_W-1:0] r_index, n_index;
    logic [SW-1:0]      r_val, n_val;
    logic [AW-1:0]      r_head, n_head;
    logic [CW-1:0]      r_count, n_count;
    logic [CW-1:0]      r_cap, n_cap;

    // Walk cursor: next logical position, reads still to issue, direction.
    logic [CW-1:0]      r_pos, n_pos;
    logic [CW-1:0]      r_left, n_left;
    logic               r_down, n_down;

    // Addresses of the last two reads, so that a word read at one slot can be
    // written back into the slot read just before it.
    logic               r_v1, n_v1;
    logic               r_v2, n_v2;
    logic [AW-1:0]      r_a1, n_a1;
    logic [AW-1:0]      r_a2, n_a2;

    logic [SW-1:0]      r_res, n_res;
    t_status            r_st, n_st;

    // Output register.
    logic               r_out_valid, n_out_valid;
    logic [VALUE_W-1:0] r_out_res, n_out_res;
    t_status            r_out_st, n_out_st;
    logic [COUNT_W-1:0] r_out_cnt, n_out_cnt;

    // Slot memory port.
    logic               w_ram_we;
    logic [AW-1:0]      w_ram_waddr;
    logic [SW-1:0]      w_ram_wdata;
    logic               w_ram_re;
    logic [AW-1:0]      w_ram_raddr;
    logic [SW-1:0]      w_ram_rdata;

    rbdl_slot_ram #(
        .DEPTH (DEPTH),
        .WIDTH (SW)
    ) u_slot_ram (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (w_ram_waddr),
        .i_wdata (w_ram_wdata),
        .i_re    (w_ram_re),
        .i_raddr (w_ram_raddr),
        .o_rdata (w_ram_rdata)
    );

    // Conditions of the request being executed.
    logic               w_accept;
    logic               w_full;
    logic               w_empty;
    logic [XW-1:0]      w_idx_x;
    logic [XW-1:0]      w_cnt_x;
    logic               w_idx_ge;
    logic               w_idx_gt;
    logic [AW-1:0]      w_head_dec;
    logic [CW-1:0]      w_head_inc;
    logic               w_match;
    t_status            w_exec_st;

    assign w_accept   = i_s_axis_tvalid && o_s_axis_tready;
    assign w_full     = (r_count >= r_cap);
    assign w_empty    = (r_count == '0);
    assign w_idx_x    = XW'(r_index);
    assign w_cnt_x    = XW'(r_count);
    assign w_idx_ge   = (w_idx_x >= w_cnt_x);
    assign w_idx_gt   = (w_idx_x > w_cnt_x);
    assign w_head_dec = (r_head == '0) ? AW'(r_cap - CW'(1)) : (r_head - AW'(1));
    assign w_head_inc = CW'(r_head) + CW'(1);
    assign w_match    = r_v1 && (w_ram_rdata == r_val);

    // Outcome of the checks made when a request starts.
    always_comb begin
        w_exec_st = STAT_OK;
        case (r_mode)
            MODE_ADD_TAIL, MODE_ADD_HEAD: begin
                if (w_full) begin
                    w_exec_st = STAT_FULL;
                end
            end
            MODE_REMOVE_HEAD, MODE_REMOVE_TAIL, MODE_GET_TAIL, MODE_REMOVE_VALUE: begin
                if (w_empty) begin
                    w_exec_st = STAT_EMPTY;
                end
            end
            MODE_INSERT_AT: begin
                if (w_full) begin
                    w_exec_st = STAT_FULL;
                end else if (w_idx_gt) begin
                    w_exec_st = STAT_RANGE;
                end
            end
            MODE_REMOVE_AT, MODE_GET_AT: begin
                if (w_idx_ge) begin
                    w_exec_st = STAT_RANGE;
                end
            end
            default: begin
                w_exec_st = STAT_RANGE;
            end
        endcase
    end

    // Shared slot address unit: physical slot of a logical position, wrapping
    // at the capacity with one compare and subtract.
    logic [CW-1:0] w_pos_sel;
    logic [CW:0]   w_sum;
    logic [AW-1:0] w_slot;

    always_comb begin
        w_pos_sel = r_pos;
        if (r_state == ST_EXEC) begin
            case (r_mode)
                MODE_ADD_TAIL:                   w_pos_sel = r_count;
                MODE_REMOVE_TAIL, MODE_GET_TAIL: w_pos_sel = r_count - CW'(1);
                MODE_GET_AT:                     w_pos_sel = CW'(r_index);
                default:                         w_pos_sel = '0;
            endcase
        end
    end

    assign w_sum  = (CW + 1)'(r_head) + (CW + 1)'(w_pos_sel);
    assign w_slot = (w_sum >= (CW + 1)'(r_cap)) ? AW'(w_sum - (CW + 1)'(r_cap)) : AW'(w_sum);

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (w_exec_st != STAT_OK) begin
                    n_state = ST_DONE;
                end else begin
                    case (r_mode)
                        MODE_REMOVE_HEAD, MODE_REMOVE_TAIL,
                        MODE_GET_TAIL, MODE_GET_AT:          n_state = ST_READ;
                        MODE_INSERT_AT, MODE_REMOVE_AT:      n_state = ST_MOVE;
                        MODE_REMOVE_VALUE:                   n_state = ST_SCAN;
                        default:                             n_state = ST_DONE;
                    endcase
                end
            end
            ST_READ: begin
                n_state = ST_DONE;
            end
            ST_SCAN: begin
                if (w_match) begin
                    n_state = ST_MOVE;
                end else if (r_left == '0 && !r_v1) begin
                    n_state = ST_DONE;
                end
            end
            ST_MOVE: begin
                if (r_left == '0 && !r_v1) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!r_out_valid || i_m_axis_tready) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Datapath, memory port and handshake outputs.
    always_comb begin
        n_mode      = r_mode;
        n_index     = r_index;
        n_val       = r_val;
        n_head      = r_head;
        n_count     = r_count;
        n_cap       = r_cap;
        n_pos       = r_pos;
        n_left      = r_left;
        n_down      = r_down;
        n_v1        = r_v1;
        n_v2        = r_v2;
        n_a1        = r_a1;
        n_a2        = r_a2;
        n_res       = r_res;
        n_st        = r_st;
        n_out_valid = r_out_valid && !i_m_axis_tready;
        n_out_res   = r_out_res;
        n_out_st    = r_out_st;
        n_out_cnt   = r_out_cnt;

        w_ram_we    = 1'b0;
        w_ram_waddr = w_slot;
        w_ram_wdata = r_val;
        w_ram_re    = 1'b0;
        w_ram_raddr = w_slot;

        o_s_axis_tready = (r_state == ST_IDLE);

        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_mode  = w_in_mode;
                    n_index = w_in_index;
                    n_val   = w_in_value[SW-1:0];
                end
            end
            ST_EXEC: begin
                n_st  = w_exec_st;
                n_res = '0;
                n_v1  = 1'b0;
                n_v2  = 1'b0;
                if (w_exec_st == STAT_OK) begin
                    case (r_mode)
                        MODE_ADD_TAIL: begin
                            w_ram_we = 1'b1;
                            n_count  = r_count + CW'(1);
                        end
                        MODE_ADD_HEAD: begin
                            w_ram_we    = 1'b1;
                            w_ram_waddr = w_head_dec;
                            n_head      = w_head_dec;
                            n_count     = r_count + CW'(1);
                        end
                        MODE_REMOVE_HEAD: begin
                            w_ram_re = 1'b1;
                            n_head   = (w_head_inc >= r_cap) ? '0 : AW'(w_head_inc);
                            n_count  = r_count - CW'(1);
                        end
                        MODE_REMOVE_TAIL: begin
                            w_ram_re = 1'b1;
                            n_count  = r_count - CW'(1);
                        end
                        MODE_GET_TAIL, MODE_GET_AT: begin
                            w_ram_re = 1'b1;
                        end
                        MODE_INSERT_AT: begin
                            // Walk from the new tail slot down to the index.
                            n_pos  = r_count;
                            n_left = r_count - CW'(r_index) + CW'(1);
                            n_down = 1'b1;
                        end
                        MODE_REMOVE_AT: begin
                            n_pos  = CW'(r_index);
                            n_left = r_count - CW'(r_index);
                            n_down = 1'b0;
                        end
                        MODE_REMOVE_VALUE: begin
                            n_pos  = '0;
                            n_left = r_count;
                            n_down = 1'b0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_READ: begin
                n_res = w_ram_rdata;
            end
            ST_SCAN: begin
                if (w_match) begin
                    // The entry read last cycle matched: remove from there.
                    n_pos  = r_pos - CW'(1);
                    n_left = r_count - r_pos + CW'(1);
                    n_v1   = 1'b0;
                    n_v2   = 1'b0;
                end else if (r_left != '0) begin
                    w_ram_re = 1'b1;
                    n_pos    = r_pos + CW'(1);
                    n_left   = r_left - CW'(1);
                    n_v1     = 1'b1;
                end else begin
                    n_v1 = 1'b0;
                    if (!r_v1) begin
                        n_st = STAT_EMPTY;
                    end
                end
            end
            ST_MOVE: begin
                if (r_v1 && r_v2) begin
                    w_ram_we    = 1'b1;
                    w_ram_waddr = r_a2;
                    w_ram_wdata = w_ram_rdata;
                end
                if (r_v1 && !r_v2 && !r_down) begin
                    n_res = w_ram_rdata;
                end
                if (r_left != '0) begin
                    w_ram_re = 1'b1;
                    n_a1     = w_slot;
                    n_a2     = r_a1;
                    n_v1     = 1'b1;
                    n_v2     = r_v1;
                    n_pos    = r_down ? (r_pos - CW'(1)) : (r_pos + CW'(1));
                    n_left   = r_left - CW'(1);
                end else if (r_v1) begin
                    n_a2 = r_a1;
                    n_v2 = 1'b1;
                    n_v1 = 1'b0;
                end else if (r_down) begin
                    // Last step of an insert: the new word goes into the
                    // slot of the index, the last one read.
                    w_ram_we    = 1'b1;
                    w_ram_waddr = r_a2;
                    n_count     = r_count + CW'(1);
                end else begin
                    n_count = r_count - CW'(1);
                end
            end
            ST_DONE: begin
                if (!r_out_valid || i_m_axis_tready) begin
                    n_out_valid = 1'b1;
                    n_out_res   = (r_st == STAT_OK) ? VALUE_W'(r_res) : '0;
                    n_out_st    = r_st;
                    n_out_cnt   = w_cnt_x[COUNT_W-1:0];
                end
            end
            default: begin
            end
        endcase

        // A capacity write empties the list; users must write in idle, unchecked.
        if (i_cfg_we) begin
            if (i_cfg_wdata == '0) begin
                n_cap = CW'(1);
            end else if (XW'(i_cfg_wdata) > XW'(DEPTH)) begin
                n_cap = CW'(DEPTH);
            end else begin
                n_cap = CW'(i_cfg_wdata);
            end
            n_count = '0;
            n_head  = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_head      <= '0;
            r_count     <= '0;
            r_cap       <= CW'(DEPTH);
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_count     <= n_count;
            r_cap       <= n_cap;
            r_v1        <= n_v1;
            r_v2        <= n_v2;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mode    <= n_mode;
        r_index   <= n_index;
        r_val     <= n_val;
        r_pos     <= n_pos;
        r_left    <= n_left;
        r_down    <= n_down;
        r_a1      <= n_a1;
        r_a2      <= n_a2;
        r_res     <= n_res;
        r_st      <= n_st;
        r_out_res <= n_out_res;
        r_out_st  <= n_out_st;
        r_out_cnt <= n_out_cnt;
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = OUT_TDATA_W'({r_out_cnt, r_out_st, r_out_res});

    // The list never holds more entries than the capacity allows.
    a_count_in_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= r_cap)
        else $error("entry count exceeds capacity");

    // The head always points at a slot inside the capacity.
    a_head_in_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        CW'(r_head) < r_cap)
        else $error("head pointer outside the capacity");

    // The store is written only when a request starts or while entries move.
    a_write_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ram_we |-> (r_state == ST_EXEC || r_state == ST_MOVE))
        else $error("slot write outside an execute or move step");

    // A failed request never reports a value.
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_st != STAT_OK) |-> (r_out_res == '0))
        else $error("non-zero value with an error status");

    // An accepted word is executed in the following cycle.
    a_accept_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state == ST_EXEC))
        else $error("accepted request not executed");

endmodule

### dv/ring_buffer_deque_list_tb.sv
`timescale 1ns / 1ps

import rbdl_pkg::*;

typedef struct packed {
    logic [VALUE_W-1:0] value;
    t_status            status;
    logic [COUNT_W-1:0] count;
} list_result_t;

// Mirror of the circular list: its own slot image, head position, entry count
// and capacity, plus the queue of result words still to come out of the block.
class deque_ledger;
    logic [VALUE_W-1:0] slots [DEPTH_DEF];
    int unsigned        head;
    int unsigned        count;
    int unsigned        cap;
    list_result_t       awaited [$];
    int unsigned        checked;
    int unsigned        errors;

    function new();
        foreach (slots[k]) slots[k] = '0;
        head    = 0;
        count   = 0;
        cap     = DEPTH_DEF;
        checked = 0;
        errors  = 0;
    endfunction

    function int unsigned slot_of(int unsigned k);
        return (head + k) % cap;
    endfunction

    function logic [VALUE_W-1:0] entry_at(int unsigned k);
        return slots[slot_of(k)];
    endfunction

    // A written capacity is clamped to 1..DEPTH and always empties the list.
    function void set_capacity(logic [CAP_W-1:0] setting);
        if (setting == 0) begin
            cap = 1;
        end else if (setting > DEPTH_DEF) begin
            cap = DEPTH_DEF;
        end else begin
            cap = 32'(setting);
        end
        head  = 0;
        count = 0;
    endfunction

    // Takes the entry at a position and closes the gap towards the head.
    function logic [VALUE_W-1:0] take_at(int unsigned at);
        logic [VALUE_W-1:0] word;
        word = slots[slot_of(at)];
        for (int unsigned i = at; i + 1 < count; i++) begin
            slots[slot_of(i)] = slots[slot_of(i + 1)];
        end
        count--;
        return word;
    endfunction

    // Applies one accepted request and queues the result word it must give.
    function void note_request(logic [MODE_W-1:0] mode, logic [INDEX_W-1:0] idx,
                               logic [VALUE_W-1:0] val);
        list_result_t       r;
        logic [VALUE_W-1:0] word;
        bit                 is_full;
        bit                 found;
        int unsigned        at;
        word     = '0;
        r.status = STAT_OK;
        found    = 1'b0;
        at       = 32'(idx);
        is_full  = (count + 1 > cap);
        case (mode)
            MODE_ADD_TAIL: begin
                if (is_full) begin
                    r.status = STAT_FULL;
                end else begin
                    slots[slot_of(count)] = val;
                    count++;
                end
            end
            MODE_ADD_HEAD: begin
                if (is_full) begin
                    r.status = STAT_FULL;
                end else begin
                    head = (head == 0) ? cap - 1 : head - 1;
                    slots[head] = val;
                    count++;
                end
            end
            MODE_REMOVE_HEAD: begin
                if (count == 0) begin
                    r.status = STAT_EMPTY;
                end else begin
                    word = slots[head];
                    head = (head + 1 >= cap) ? 0 : head + 1;
                    count--;
                end
            end
            MODE_REMOVE_TAIL: begin
                if (count == 0) begin
                    r.status = STAT_EMPTY;
                end else begin
                    word = slots[slot_of(count - 1)];
                    count--;
                end
            end
            MODE_INSERT_AT: begin
                if (is_full) begin
                    r.status = STAT_FULL;
                end else if (at > count) begin
                    r.status = STAT_RANGE;
                end else begin
                    for (int unsigned i = count; i > at; i--) begin
                        slots[slot_of(i)] = slots[slot_of(i - 1)];
                    end
                    slots[slot_of(at)] = val;
                    count++;
                end
            end
            MODE_REMOVE_AT: begin
                if (at >= count) begin
                    r.status = STAT_RANGE;
                end else begin
                    word = take_at(at);
                end
            end
            MODE_GET_AT: begin
                if (at >= count) begin
                    r.status = STAT_RANGE;
                end else begin
                    word = slots[slot_of(at)];
                end
            end
            MODE_REMOVE_VALUE: begin
                r.status = STAT_EMPTY;
                for (int unsigned i = 0; i < count && !found; i++) begin
                    if (slots[slot_of(i)] == val) begin
                        word     = take_at(i);
                        r.status = STAT_OK;
                        found    = 1'b1;
                    end
                end
            end
            MODE_GET_TAIL: begin
                if (count == 0) begin
                    r.status = STAT_EMPTY;
                end else begin
                    word = slots[slot_of(count - 1)];
                end
            end
            default: begin
                r.status = STAT_RANGE;
            end
        endcase
        if (r.status != STAT_OK) begin
            word = '0;
        end
        r.value = word;
        r.count = COUNT_W'(count);
        awaited.push_back(r);
    endfunction

    // Only the first few dozen mismatches are printed; all of them are counted.
    task flag_mismatch(string what);
        errors++;
        if (errors <= 40) begin
            $display("MISMATCH at result %0d, %0t: %s", checked, $time, what);
        end
    endtask

    task check_result(logic [VALUE_W-1:0] got_value, logic [STATUS_W-1:0] got_status,
                      logic [COUNT_W-1:0] got_count);
        list_result_t want;
        if (awaited.size() == 0) begin
            flag_mismatch($sformatf("unexpected word: value %h status %0d count %0d",
                                    got_value, got_status, got_count));
            return;
        end
        want = awaited.pop_front();
        checked++;
        if (got_value !== want.value) begin
            flag_mismatch($sformatf("value %h, expected %h", got_value, want.value));
        end
        if (got_status !== want.status) begin
            flag_mismatch($sformatf("status %0d, expected %0d", got_status, want.status));
        end
        if (got_count !== want.count) begin
            flag_mismatch($sformatf("count %0d, expected %0d", got_count, want.count));
        end
    endtask
endclass

module ring_buffer_deque_list_tb;

    // The slowest request walks the whole store, and this limit leaves a wide
    // margin over the worst case for about a thousand words.
    localparam int CYCLE_LIMIT = 400000;
    localparam logic [MODE_W-1:0] MODE_SPARE_FIRST = 4'd9;
    localparam logic [MODE_W-1:0] MODE_SPARE_LAST  = 4'd15;
    localparam int IN_FILL_W = IN_TDATA_W - MODE_W - INDEX_W - VALUE_W;

    logic                   i_clk           = 1'b0;
    logic                   i_rst_n         = 1'b0;
    logic                   i_cfg_we        = 1'b0;
    logic [CAP_W-1:0]       i_cfg_wdata     = '0;
    logic                   i_s_axis_tvalid = 1'b0;
    logic                   o_s_axis_tready;
    // Fields from bit 0: mode (4), index (7), value (32), zero fill.
    logic [IN_TDATA_W-1:0]  i_s_axis_tdata  = '0;
    logic                   o_m_axis_tvalid;
    logic                   i_m_axis_tready = 1'b0;
    // Fields from bit 0: result_value (32), status (2), entry_count (7), zero fill.
    logic [OUT_TDATA_W-1:0] o_m_axis_tdata;

    deque_ledger ledger;
    // While calm is set neither side idles nor stalls.
    bit          calm          = 1'b0;
    int unsigned sent_words    = 0;
    int unsigned settings_seen = 0;
    int unsigned cycle_count   = 0;

    ring_buffer_deque_list DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d result words still awaited.",
                     cycle_count, ledger.awaited.size());
            $display("DONE: errors detected");
            $finish;
        end
    end

    // The receiver stalls with a chance of 29 in a hundred, drawn afresh each
    // cycle, so that stalls land on every phase of the block's work.
    always @(posedge i_clk) begin
        i_m_axis_tready <= calm || ($urandom_range(99) >= 29);
    end

    // Every result word taken off the master side is checked against the
    // oldest expectation. Inputs are sampled at the edge, before any update.
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            ledger.check_result(o_m_axis_tdata[VALUE_W-1:0],
                                o_m_axis_tdata[VALUE_W+STATUS_W-1:VALUE_W],
                                o_m_axis_tdata[VALUE_W+STATUS_W+COUNT_W-1:VALUE_W+STATUS_W]);
        end
    end

    // Presents one request word, with random idle cycles in front of it unless
    // the run is calm, and holds it until the block takes it. The word is
    // handed to the ledger at the very edge at which it is accepted.
    task automatic send_request(input logic [MODE_W-1:0] mode,
                                input logic [INDEX_W-1:0] idx,
                                input logic [VALUE_W-1:0] val);
        while (!calm && $urandom_range(99) < 29) begin
            i_s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {{IN_FILL_W{1'b0}}, val, idx, mode};
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        ledger.note_request(mode, idx, val);
        sent_words++;
    endtask

    // The capacity may only change while the block is idle, so every result
    // word must be home first. Each write also empties the list.
    task automatic write_capacity(input logic [CAP_W-1:0] setting);
        i_s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (ledger.awaited.size() != 0) @(posedge i_clk);
        repeat (2) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= setting;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        ledger.set_capacity(setting);
        settings_seen++;
    endtask

    // One random request. While growing, pushes dominate so that the list
    // reaches full; while shrinking, pops dominate so that it drains to empty.
    // Indexes mostly fall within the list, and searches mostly look for a word
    // that is held, so that indexed moves and first-match removal are reached.
    task automatic random_request(input bit grow);
        t_mode              order [9];
        int unsigned        cut [2][10];
        logic [MODE_W-1:0]  mode;
        logic [INDEX_W-1:0] idx;
        logic [VALUE_W-1:0] val;
        int unsigned        roll;
        int unsigned        held;
        int unsigned        k;
        order = '{MODE_ADD_TAIL, MODE_ADD_HEAD, MODE_INSERT_AT, MODE_REMOVE_HEAD,
                  MODE_REMOVE_TAIL, MODE_REMOVE_AT, MODE_GET_AT, MODE_REMOVE_VALUE,
                  MODE_GET_TAIL};
        cut   = '{'{8, 14, 20, 36, 52, 66, 76, 88, 95, 100},
                  '{35, 60, 75, 78, 81, 84, 90, 94, 98, 100}};
        held  = ledger.count;
        roll  = $urandom_range(99);
        k     = 0;
        while (k < 9 && roll >= cut[grow][k]) k++;
        if (k < 9) begin
            mode = order[k];
        end else begin
            mode = MODE_W'($urandom_range(MODE_SPARE_FIRST, MODE_SPARE_LAST));
        end
        if ($urandom_range(99) < 85) begin
            idx = INDEX_W'($urandom_range(held, 0));
        end else begin
            idx = INDEX_W'($urandom_range(DEPTH_DEF, 0));
        end
        roll = $urandom_range(99);
        if (mode == MODE_REMOVE_VALUE && held != 0 && roll < 70) begin
            val = ledger.entry_at($urandom_range(held - 1, 0));
        end else if (roll < 55) begin
            // Small words repeat often, which gives duplicates in the list.
            val = $urandom_range(15, 0);
        end else begin
            val = $urandom;
        end
        send_request(mode, idx, val);
    endtask

    initial begin
        logic [CAP_W-1:0] caps [8];
        int unsigned      lens [8];
        ledger = new();
        // Settings for the random phases: an over-range value and zero are
        // both clamped by the block, and the full store is run without idling.
        caps = '{7'd127, 7'd0, 7'd7, 7'd64, 7'd33, 7'd1, 7'd100, 7'd2};
        lens = '{200, 70, 80, 200, 150, 60, 120, 70};

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed words at the capacity left by reset: pops and reads on
        // an empty list, the spare mode codes, and the widest fields.
        send_request(MODE_REMOVE_HEAD, 7'd0, 32'h0);
        send_request(MODE_GET_TAIL, 7'd0, 32'h0);
        send_request(MODE_REMOVE_AT, 7'd0, 32'h0);
        send_request(MODE_REMOVE_VALUE, 7'd0, 32'h0);
        send_request(MODE_SPARE_LAST, 7'd64, 32'hFFFF_FFFF);
        send_request(MODE_SPARE_FIRST, 7'd0, 32'h0);
        send_request(MODE_ADD_TAIL, 7'd64, 32'hFFFF_FFFF);
        send_request(MODE_GET_AT, 7'd64, 32'h0);
        send_request(MODE_GET_AT, 7'd0, 32'h0);

        // A two-slot list: pushes at both ends up to full, refusals when full
        // (an insert past the end still reports full), reads, a failed and a
        // successful search, an out-of-range insert, an append by insert at
        // the count, an insert that moves an entry, and a drain to empty.
        write_capacity(7'd2);
        send_request(MODE_ADD_TAIL, 7'd0, 32'h1111_1111);
        send_request(MODE_ADD_HEAD, 7'd0, 32'h2222_2222);
        send_request(MODE_ADD_TAIL, 7'd0, 32'h3333_3333);
        send_request(MODE_ADD_HEAD, 7'd0, 32'h4444_4444);
        send_request(MODE_INSERT_AT, 7'd64, 32'h5555_5555);
        send_request(MODE_GET_AT, 7'd1, 32'h0);
        send_request(MODE_GET_AT, 7'd2, 32'h0);
        send_request(MODE_GET_TAIL, 7'd0, 32'h0);
        send_request(MODE_REMOVE_VALUE, 7'd0, 32'h3333_3333);
        send_request(MODE_REMOVE_VALUE, 7'd0, 32'h1111_1111);
        send_request(MODE_INSERT_AT, 7'd2, 32'h6666_6666);
        send_request(MODE_INSERT_AT, 7'd1, 32'h7777_7777);
        send_request(MODE_REMOVE_AT, 7'd1, 32'h0);
        send_request(MODE_INSERT_AT, 7'd0, 32'h0);
        send_request(MODE_REMOVE_AT, 7'd0, 32'h0);
        send_request(MODE_REMOVE_TAIL, 7'd0, 32'h0);
        send_request(MODE_REMOVE_HEAD, 7'd0, 32'h0);

        // Random phases, each under its own capacity: the first three fifths
        // of a phase fill the list, the rest drain it.
        for (int p = 0; p < 8; p++) begin
            write_capacity(caps[p]);
            calm = (caps[p] == 7'd64);
            for (int n = 0; n < lens[p]; n++) begin
                random_request(n < (lens[p] * 3) / 5);
            end
        end
        calm = 1'b0;

        i_s_axis_tvalid <= 1'b0;
        while (ledger.awaited.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);

        $display("Ran %0d request words and checked %0d result words under %0d capacity",
                 sent_words, ledger.checked, settings_seen + 1);
        $display("settings, from one slot to the full store, through full and empty lists.");
        if (ledger.errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
